FILE: rtl/adp_pkg.sv
// Shared types, codes and helpers for the archive directory parser.
package adp_pkg;

  localparam int HDR_BYTES   = 12;
  localparam int ENTRY_BYTES = 16;
  localparam int NAME_BYTES  = 8;
  localparam int CNT_W       = 28;
  localparam int IDX_W       = $clog2(ENTRY_BYTES);

  localparam logic [7:0] CH_I       = 8'h49;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_W       = 8'h57;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_NEGATIVE   = 3'd3,
    ST_BEYOND_END = 3'd4,
    ST_EARLY_END  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DIR    = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ERROR   = 2'd1,
    ACT_SUMMARY = 2'd2,
    ACT_ENTRY   = 2'd3
  } act_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic               is_internal;
    logic [CNT_W-1:0]   entry_total;
    logic [CNT_W-1:0]   entry_number;
    logic [31:0]        lump_position;
    logic [31:0]        lump_length;
    logic [63:0]        lump_name;
    logic [3:0]         name_length;
    logic               final_res;
  } result_t;

  typedef struct packed {
    logic [63:0] name;
    logic [3:0]  len;
  } name_t;

  // Upper-case the name and cut it at the first NUL.
  function automatic name_t fix_name(input logic [63:0] raw);
    name_t      r;
    logic       stop;
    logic [7:0] c;
    r    = '0;
    stop = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      c = raw[8*k +: 8];
      if (c == 8'h00) stop = 1'b1;
      if (!stop) begin
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_GAP;
        r.name[8*k +: 8] = c;
        r.len = r.len + 4'd1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/adp_if.sv
// Channel interfaces: the byte stream in and the result records out.
interface adp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface adp_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  status;
  logic        is_internal;
  logic [27:0] entry_total;
  logic [27:0] entry_number;
  logic [31:0] lump_position;
  logic [31:0] lump_length;
  logic [63:0] lump_name;
  logic [3:0]  name_length;
  logic        final_res;
  modport source(output valid, result_kind, status, is_internal, entry_total, entry_number,
                 lump_position, lump_length, lump_name, name_length, final_res,
                 input ready);
  modport sink(input valid, result_kind, status, is_internal, entry_total, entry_number,
               lump_position, lump_length, lump_name, name_length, final_res,
               output ready);
endinterface

FILE: rtl/archive_directory_parser_unit.sv
// Top level of the archive directory parser.
//
//  channel      dir   transaction carries
//  -----------  ----  -------------------------------------------------------
//  byte_stream  in    data_byte, end_of_file (one archive byte, file order)
//  record       out   summary / directory entry / error record
//  cfg_wr_*     in    file_length register write (no read-back)
//
// One byte per clock while the record channel is not stalled: a transaction
// sits in the input register, is decoded there against the parser state, and
// any record lands in the result register when the byte is taken from it.
// rst (synchronous) returns the parser to the header phase and clears
// file_length. A stalled record holds the result register; the input
// register still takes a byte whenever the record leaves in the same cycle.
// After the final record or an error, further bytes are taken and dropped.
module archive_directory_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  adp_byte_if.sink    byte_stream,
  adp_rec_if.source   record
);
  import adp_pkg::*;

  logic    held;
  logic    take;
  logic    slot_free;
  logic    emit;
  item_t   item;
  result_t res;

  // a held byte moves on when the result register can take its record
  assign take = held && slot_free;

  adp_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .take        (take),
    .held        (held),
    .item        (item)
  );

  // header checks, directory entry decode and all parser counters
  adp_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .item        (item),
    .emit        (emit),
    .res         (res)
  );

  adp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && emit),
    .d         (res),
    .slot_free (slot_free),
    .record    (record)
  );

endmodule

FILE: rtl/adp_in_stage.sv
// Input register for the byte stream.
module adp_in_stage (
  input  logic          clk,
  input  logic          rst,
  adp_byte_if.sink      byte_stream,
  input  logic          take,
  output logic          held,
  output adp_pkg::item_t item
);
  import adp_pkg::*;

  logic accept;

  assign byte_stream.ready = !held || take;
  assign accept = byte_stream.valid && byte_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte   <= byte_stream.data_byte;
      item.end_of_file <= byte_stream.end_of_file;
    end
  end

endmodule

FILE: rtl/adp_parse_core.sv
// Parser state and per-byte header / directory decode.
module adp_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic             take,
  input  adp_pkg::item_t   item,
  output logic             emit,
  output adp_pkg::result_t res
);
  import adp_pkg::*;

  logic [31:0]      file_length;
  logic [31:0]      byte_position;
  logic [31:0]      directory_start;
  logic [7:0]       header_store [HDR_BYTES];
  logic [7:0]       entry_store  [ENTRY_BYTES];
  logic [CNT_W-1:0] entries_expected;
  logic [CNT_W-1:0] entries_done;
  phase_t           phase, phase_next;

  // header view with the current byte in the last slot, padded to 16
  logic [7:0]       hb [ENTRY_BYTES];
  logic [7:0]       eb [ENTRY_BYTES];
  logic [31:0]      lumps, ofs, span;
  logic [CNT_W-1:0] maxe, cnt;
  logic             magic_ok, hdr_internal, ofs_small;
  logic [7:0]       ov_byte [ENTRY_BYTES];
  logic             ov_en   [ENTRY_BYTES];

  logic [IDX_W-1:0] idx;
  logic             in_dir, last;
  logic [31:0]      fpos, fsize, avail;
  logic             ent_ok;
  name_t            nm;

  act_t             act;
  status_t          err;

  always_comb begin
    for (int k = 0; k < ENTRY_BYTES; k++) begin
      if (k == HDR_BYTES - 1) hb[k] = item.data_byte;
      else if (k < HDR_BYTES) hb[k] = header_store[k];
      else hb[k] = 8'h00;
      eb[k] = (k == ENTRY_BYTES - 1) ? item.data_byte : entry_store[k];
    end
  end

  assign lumps = {hb[7], hb[6], hb[5], hb[4]};
  assign ofs   = {hb[11], hb[10], hb[9], hb[8]};
  assign magic_ok = (hb[1] == CH_W) && (hb[2] == CH_A) && (hb[3] == CH_D) &&
                    ((hb[0] == CH_I) || (hb[0] == CH_P));
  assign hdr_internal = (hb[0] == CH_I);
  assign span = file_length - ofs;
  assign maxe = span[31:IDX_W];
  assign cnt  = (lumps < {4'b0, maxe}) ? lumps[CNT_W-1:0] : maxe;
  assign ofs_small = ofs < 32'(HDR_BYTES);

  // directory bytes that sit inside the header
  always_comb begin
    logic [4:0] src;
    for (int j = 0; j < ENTRY_BYTES; j++) begin
      src = 5'(j) + {1'b0, ofs[3:0]};
      ov_en[j]   = ofs_small && (src < 5'(HDR_BYTES));
      ov_byte[j] = hb[src[3:0]];
    end
  end

  assign idx    = byte_position[IDX_W-1:0] - directory_start[IDX_W-1:0];
  assign in_dir = byte_position >= directory_start;
  assign last   = ({1'b0, entries_done} + 29'd1) >= {1'b0, entries_expected};
  assign fpos   = {eb[3], eb[2], eb[1], eb[0]};
  assign fsize  = {eb[7], eb[6], eb[5], eb[4]};
  assign ent_ok = !fpos[31] && !fsize[31] && (fpos <= file_length);
  assign avail  = file_length - fpos;
  assign nm     = fix_name({eb[15], eb[14], eb[13], eb[12], eb[11], eb[10], eb[9], eb[8]});

  // what this byte does
  always_comb begin
    act = ACT_NONE;
    err = ST_OK;
    unique case (phase)
      PH_HEADER: begin
        if (file_length < 32'(HDR_BYTES)) begin
          act = ACT_ERROR; err = ST_TOO_SHORT;
        end else if (byte_position < 32'(HDR_BYTES - 1)) begin
          if (item.end_of_file) begin
            act = ACT_ERROR; err = ST_EARLY_END;
          end
        end else if (!magic_ok) begin
          act = ACT_ERROR; err = ST_BAD_MAGIC;
        end else if (lumps[31] || ofs[31]) begin
          act = ACT_ERROR; err = ST_NEGATIVE;
        end else if (ofs > file_length) begin
          act = ACT_ERROR; err = ST_BEYOND_END;
        end else if ((cnt != '0) && item.end_of_file) begin
          act = ACT_ERROR; err = ST_EARLY_END;
        end else begin
          act = ACT_SUMMARY;
        end
      end
      PH_DIR: begin
        if (in_dir && (idx == IDX_W'(ENTRY_BYTES - 1))) begin
          if (item.end_of_file && !last) begin
            act = ACT_ERROR; err = ST_EARLY_END;
          end else begin
            act = ACT_ENTRY;
          end
        end else if (item.end_of_file) begin
          act = ACT_ERROR; err = ST_EARLY_END;
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        if (act == ACT_ERROR) phase_next = PH_DONE;
        else if (act == ACT_SUMMARY) phase_next = (cnt == '0) ? PH_DONE : PH_DIR;
      end
      PH_DIR: begin
        if (act == ACT_ERROR || (act == ACT_ENTRY && last)) phase_next = PH_DONE;
      end
      default: phase_next = phase;
    endcase
  end

  // result fields
  always_comb begin
    emit = (act != ACT_NONE);
    res  = '0;
    unique case (act)
      ACT_ERROR: begin
        res.kind      = KIND_ERROR;
        res.status    = err;
        res.final_res = 1'b1;
      end
      ACT_SUMMARY: begin
        res.kind        = KIND_SUMMARY;
        res.is_internal = hdr_internal;
        res.entry_total = cnt;
        res.final_res   = (cnt == '0);
      end
      ACT_ENTRY: begin
        res.kind          = KIND_ENTRY;
        res.is_internal   = (header_store[0] == CH_I);
        res.entry_total   = entries_expected;
        res.entry_number  = entries_done;
        res.lump_position = ent_ok ? fpos : 32'd0;
        res.lump_length   = ent_ok ? ((fsize < avail) ? fsize : avail) : 32'd0;
        res.lump_name     = nm.name;
        res.name_length   = nm.len;
        res.final_res     = last;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length      <= '0;
      byte_position    <= '0;
      directory_start  <= '0;
      entries_expected <= '0;
      entries_done     <= '0;
      phase            <= PH_HEADER;
    end else begin
      if (cfg_wr_en) file_length <= cfg_wr_data;
      if (take && phase != PH_DONE) begin
        byte_position <= byte_position + 32'd1;
        phase         <= phase_next;
        if (act == ACT_SUMMARY) begin
          entries_expected <= cnt;
          entries_done     <= '0;
          directory_start  <= ofs;
        end
        if (act == ACT_ENTRY) entries_done <= entries_done + CNT_W'(1);
      end
    end
  end

  // byte stores: no reset, every read byte is written first
  always_ff @(posedge clk) begin
    if (take) begin
      if (phase == PH_HEADER && byte_position < 32'(HDR_BYTES)) begin
        header_store[byte_position[3:0]] <= item.data_byte;
      end
      if (act == ACT_SUMMARY) begin
        for (int j = 0; j < ENTRY_BYTES; j++) begin
          if (ov_en[j]) entry_store[j] <= ov_byte[j];
        end
      end
      if (phase == PH_DIR && in_dir) entry_store[idx] <= item.data_byte;
    end
  end

endmodule

FILE: rtl/adp_out_stage.sv
// Result register driving the record channel.
module adp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  adp_pkg::result_t d,
  output logic             slot_free,
  adp_rec_if.source        record
);
  import adp_pkg::*;

  logic    res_valid;
  result_t res;

  assign slot_free = !res_valid || record.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (record.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= d;
  end

  assign record.valid         = res_valid;
  assign record.result_kind   = res.kind;
  assign record.status        = res.status;
  assign record.is_internal   = res.is_internal;
  assign record.entry_total   = res.entry_total;
  assign record.entry_number  = res.entry_number;
  assign record.lump_position = res.lump_position;
  assign record.lump_length   = res.lump_length;
  assign record.lump_name     = res.lump_name;
  assign record.name_length   = res.name_length;
  assign record.final_res     = res.final_res;

endmodule
